### sv/ptss_pkg.sv
// Package for the per-second traffic statistics block.
// Holds sizes, constants and the item type shared by the front end, the
// queue and the back end. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ptss_pkg;

  // Address set sizes.
  localparam int MAX_ADDRS = 64;
  localparam int ANY_ADDRS = 2 * MAX_ADDRS;
  localparam int SRC_AW = $clog2(MAX_ADDRS);
  localparam int ANY_AW = $clog2(ANY_ADDRS);
  localparam int SRC_FW = $clog2(MAX_ADDRS + 1);
  localparam int ANY_FW = $clog2(ANY_ADDRS + 1);
  localparam logic [SRC_FW-1:0] SRC_CAP = SRC_FW'(MAX_ADDRS);
  localparam logic [ANY_FW-1:0] ANY_CAP = ANY_FW'(ANY_ADDRS);

  // Time and arithmetic constants.
  localparam int TIME_W = 52;
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 24;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [9:0] MILLI = 10'd1000;
  localparam logic [25:0] MLEN_MAX = 26'd65535000;
  localparam logic [19:0] GAP_MAX = 20'd999999;
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  // Queue between front end and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW = $clog2(QUEUE_DEPTH);

  // What the back end has to do with an item.
  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_SAME,
    KIND_NEW
  } kind_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    kind_t              kind;
    logic               flow_end;
    logic [31:0]        bucket;
    logic [TIME_W-1:0]  t;
    logic [15:0]        len;
    logic [31:0]        sa;
    logic [31:0]        da;
  } item_t;

endpackage
`default_nettype wire

### sv/ptss_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ptss_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none
module ptss_div import ptss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic                   done,
  output logic [DIV_NW-1:0]      quo
);

  localparam int CW = $clog2(DIV_NW);
  localparam logic [CW-1:0] LAST = CW'(DIV_NW - 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              take;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    shifted = {rem_r, num_r[DIV_NW-1]};
    diff = shifted - {1'b0, den_r};
    take = (shifted >= {1'b0, den_r});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; the dividend register collects the quotient bits.
  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      num_r <= {num_r[DIV_NW-2:0], take};
    end
  end

  assign done = done_r;
  assign quo = num_r;

endmodule
`default_nettype wire

### sv/ptss_fifo.sv
// Short queue of classified items between the front end and the back end.
// Depends on ptss_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none
module ptss_fifo import ptss_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      pop_item,
  output logic       empty
);

  item_t            mem_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push;
  logic             do_pop;

  assign full = (count_r == (QAW+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule
`default_nettype wire

### sv/ptss_front.sv
// Front end: accepts packet records, places them in one-second buckets,
// drops late records and tracks flow runs. Depends on ptss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptss_front import ptss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [31:0] in_ts_seconds,
  input  wire logic [19:0] in_ts_micros,
  input  wire logic [15:0] in_packet_length,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  output logic             q_push,
  output item_t            q_item,
  input  wire logic        q_full
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_CLASS
  } fstate_t;

  fstate_t state_r;

  // Held item.
  logic [31:0] sec_r;
  logic [19:0] us_r;
  logic [15:0] len_r;
  logic [31:0] sa_r;
  logic [31:0] da_r;
  logic [15:0] sp_r;
  logic [15:0] dp_r;

  // Results of the first step.
  logic [TIME_W-1:0]  t_r;
  logic signed [32:0] dsec_r;
  logic signed [20:0] dus_r;

  // Bucket and flow state.
  logic        started_r;
  logic [31:0] origin_sec_r;
  logic [19:0] origin_us_r;
  logic [31:0] cur_bucket_r;
  logic [31:0] psa_r;
  logic [31:0] pda_r;
  logic [15:0] psp_r;
  logic [15:0] pdp_r;
  logic        in_run_r;

  logic signed [2:0]  frac;
  logic signed [33:0] q_s;
  logic               late;
  logic [31:0]        bucket;
  logic               match;
  logic               drop;
  kind_t              kind;

  assign in_full = (state_r != F_IDLE);

  // The microsecond difference moves the whole-second count by -2 to +1.
  always_comb begin
    if (dus_r >= 21'sd1000000) begin
      frac = 3'sd1;
    end else if (dus_r >= 21'sd0) begin
      frac = 3'sd0;
    end else if (dus_r >= -21'sd1000000) begin
      frac = -3'sd1;
    end else begin
      frac = -3'sd2;
    end
    q_s = $signed({dsec_r[32], dsec_r}) + $signed({{31{frac[2]}}, frac});
    late = q_s[33];
    if (q_s[32] || q_s[31:0] == 32'hFFFFFFFF) begin
      bucket = 32'hFFFFFFFF;
    end else begin
      bucket = q_s[31:0] + 32'd1;
    end
  end

  // Classify against the previous record and the open bucket.
  always_comb begin
    match = ((psa_r == sa_r && pda_r == da_r) || (psa_r == da_r && pda_r == sa_r)) &&
            ((psp_r == sp_r && pdp_r == dp_r) || (psp_r == dp_r && pdp_r == sp_r));
    drop = started_r && (late || bucket < cur_bucket_r);
    if (!started_r) begin
      kind = KIND_FIRST;
    end else if (bucket == cur_bucket_r) begin
      kind = KIND_SAME;
    end else begin
      kind = KIND_NEW;
    end
    q_push = (state_r == F_CLASS) && !drop;
    q_item.kind = kind;
    q_item.flow_end = started_r && !match && in_run_r;
    q_item.bucket = started_r ? bucket : 32'd1;
    q_item.t = t_r;
    q_item.len = len_r;
    q_item.sa = sa_r;
    q_item.da = da_r;
  end

  // State machine and registered state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      started_r <= 1'b0;
      origin_sec_r <= '0;
      origin_us_r <= '0;
      cur_bucket_r <= 32'd1;
      psa_r <= '0;
      pda_r <= '0;
      psp_r <= '0;
      pdp_r <= '0;
      in_run_r <= 1'b0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_push) state_r <= F_CALC;
        end
        F_CALC: begin
          state_r <= F_CLASS;
        end
        F_CLASS: begin
          if (drop) begin
            state_r <= F_IDLE;
          end else if (!q_full) begin
            state_r <= F_IDLE;
            psa_r <= sa_r;
            pda_r <= da_r;
            psp_r <= sp_r;
            pdp_r <= dp_r;
            in_run_r <= (kind == KIND_SAME) ? match : 1'b0;
            if (!started_r) begin
              started_r <= 1'b1;
              origin_sec_r <= sec_r;
              origin_us_r <= us_r;
              cur_bucket_r <= 32'd1;
            end else if (kind == KIND_NEW) begin
              cur_bucket_r <= bucket;
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // Item capture and time arithmetic.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_push) begin
      sec_r <= in_ts_seconds;
      us_r <= in_ts_micros;
      len_r <= in_packet_length;
      sa_r <= in_src_addr;
      da_r <= in_dst_addr;
      sp_r <= in_src_port;
      dp_r <= in_dst_port;
    end
    if (state_r == F_CALC) begin
      t_r <= {20'd0, sec_r} * {32'd0, USEC_PER_SEC} + {32'd0, us_r};
      dsec_r <= $signed({1'b0, sec_r} - {1'b0, origin_sec_r});
      dus_r <= $signed({1'b0, us_r} - {1'b0, origin_us_r});
    end
  end

endmodule
`default_nettype wire

### sv/ptss_back.sv
// Back end: keeps the open bucket's totals and address sets, and at bucket
// close works out the means and hands over the report.
// Depends on ptss_pkg and ptss_div.
`timescale 1ns / 1ps
`default_nettype none
module ptss_back import ptss_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  output logic        q_pop,
  input  wire item_t  q_item,
  output logic        out_empty,
  input  wire logic   out_pop,
  output logic [31:0] out_bucket_number,
  output logic [23:0] out_flow_count,
  output logic [23:0] out_packet_count,
  output logic [31:0] out_byte_total,
  output logic [25:0] out_mean_length_milli,
  output logic [19:0] out_mean_gap_micros,
  output logic [6:0]  out_distinct_sources,
  output logic [6:0]  out_distinct_destinations,
  output logic [7:0]  out_distinct_any,
  output logic        out_table_overflow
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_LEN,
    B_DIV_GAP,
    B_EMIT,
    B_OPEN,
    B_SCAN,
    B_INS_A,
    B_INS_B
  } bstate_t;

  bstate_t state_r;
  item_t   it_r;

  // Bucket totals.
  logic [31:0]       cur_bucket_r;
  logic [23:0]       packets_r;
  logic [31:0]       bytes_r;
  logic [23:0]       flows_r;
  logic [TIME_W-1:0] first_r;
  logic [TIME_W-1:0] last_r;
  logic [SRC_FW-1:0] src_fill_r;
  logic [SRC_FW-1:0] dst_fill_r;
  logic [ANY_FW-1:0] any_fill_r;
  logic              ovf_r;
  logic [25:0]       mlen_r;
  logic [19:0]       gap_r;

  // Address sets.
  logic [31:0] src_mem [MAX_ADDRS];
  logic [31:0] dst_mem [MAX_ADDRS];
  logic [31:0] any_mem [ANY_ADDRS];
  logic [31:0] rd_src_r;
  logic [31:0] rd_dst_r;
  logic [31:0] rd_any_r;

  // Set scan.
  logic [ANY_FW-1:0] scan_k_r;
  logic [ANY_FW-1:0] kd_r;
  logic              kv_r;
  logic              src_found_r;
  logic              dst_found_r;
  logic              anys_found_r;
  logic              anyd_found_r;
  logic [ANY_FW-1:0] lim;
  logic              hit_src;
  logic              hit_dst;
  logic              hit_anys;
  logic              hit_anyd;

  // Set writes.
  logic              src_we;
  logic              dst_we;
  logic              any_we;
  logic [31:0]       any_wdata;
  logic              src_new;
  logic              dst_new;
  logic              anys_new;
  logic              anyd_new;

  // Report output register.
  logic        out_valid_r;
  logic [31:0] o_bucket_r;
  logic [23:0] o_flows_r;
  logic [23:0] o_packets_r;
  logic [31:0] o_bytes_r;
  logic [25:0] o_mlen_r;
  logic [19:0] o_gap_r;
  logic [6:0]  o_src_r;
  logic [6:0]  o_dst_r;
  logic [7:0]  o_any_r;
  logic        o_ovf_r;

  // Divider hookup.
  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;

  logic [TIME_W-1:0] span;
  logic              div_gap_ok;

  ptss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Arithmetic on the bucket totals.
  always_comb begin
    span = (last_r >= first_r) ? (last_r - first_r) : '0;
    div_gap_ok = (packets_r >= 24'd2);
  end

  // Divider requests: mean length first, then mean gap.
  always_comb begin
    div_start = 1'b0;
    div_num = DIV_NW'(bytes_r) * DIV_NW'(MILLI);
    div_den = packets_r;
    if (state_r == B_IDLE && !q_empty && q_item.kind == KIND_NEW) begin
      div_start = 1'b1;
    end else if (state_r == B_DIV_LEN && div_done && div_gap_ok) begin
      div_start = 1'b1;
      div_num = span;
      div_den = packets_r - 24'd1;
    end
  end

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  // Set lookups compare the registered read data of the previous index.
  always_comb begin
    lim = any_fill_r;
    if (ANY_FW'(src_fill_r) > lim) lim = ANY_FW'(src_fill_r);
    if (ANY_FW'(dst_fill_r) > lim) lim = ANY_FW'(dst_fill_r);
    hit_src = kv_r && (kd_r < ANY_FW'(src_fill_r)) && (rd_src_r == it_r.sa);
    hit_dst = kv_r && (kd_r < ANY_FW'(dst_fill_r)) && (rd_dst_r == it_r.da);
    hit_anys = kv_r && (kd_r < any_fill_r) && (rd_any_r == it_r.sa);
    hit_anyd = kv_r && (kd_r < any_fill_r) && (rd_any_r == it_r.da);
  end

  // Insertion of addresses that were not found.
  always_comb begin
    src_new = (state_r == B_INS_A) && !src_found_r;
    dst_new = (state_r == B_INS_A) && !dst_found_r;
    anys_new = (state_r == B_INS_A) && !anys_found_r;
    anyd_new = (state_r == B_INS_B) && !anyd_found_r && (it_r.da != it_r.sa);
    src_we = src_new && (src_fill_r < SRC_CAP);
    dst_we = dst_new && (dst_fill_r < SRC_CAP);
    any_we = (anys_new || anyd_new) && (any_fill_r < ANY_CAP);
    any_wdata = anyd_new ? it_r.da : it_r.sa;
  end

  // Set memories, with registered reads.
  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_fill_r[SRC_AW-1:0]] <= it_r.sa;
    if (dst_we) dst_mem[dst_fill_r[SRC_AW-1:0]] <= it_r.da;
    if (any_we) any_mem[any_fill_r[ANY_AW-1:0]] <= any_wdata;
    rd_src_r <= src_mem[scan_k_r[SRC_AW-1:0]];
    rd_dst_r <= dst_mem[scan_k_r[SRC_AW-1:0]];
    rd_any_r <= any_mem[scan_k_r[ANY_AW-1:0]];
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (q_pop) it_r <= q_item;
  end

  // Main sequencer with the bucket state and the report register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cur_bucket_r <= 32'd1;
      packets_r <= '0;
      bytes_r <= '0;
      flows_r <= '0;
      first_r <= '0;
      last_r <= '0;
      src_fill_r <= '0;
      dst_fill_r <= '0;
      any_fill_r <= '0;
      ovf_r <= 1'b0;
      scan_k_r <= '0;
      kd_r <= '0;
      kv_r <= 1'b0;
      src_found_r <= 1'b0;
      dst_found_r <= 1'b0;
      anys_found_r <= 1'b0;
      anyd_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            unique case (q_item.kind)
              KIND_FIRST: state_r <= B_OPEN;
              KIND_SAME: begin
                if (q_item.flow_end && flows_r != CNT_MAX) flows_r <= flows_r + 24'd1;
                if (packets_r != CNT_MAX) packets_r <= packets_r + 24'd1;
                if (({1'b0, bytes_r} + {17'd0, q_item.len}) > 33'h0FFFFFFFF) begin
                  bytes_r <= 32'hFFFFFFFF;
                end else begin
                  bytes_r <= bytes_r + {16'd0, q_item.len};
                end
                last_r <= q_item.t;
                scan_k_r <= '0;
                kv_r <= 1'b0;
                src_found_r <= 1'b0;
                dst_found_r <= 1'b0;
                anys_found_r <= 1'b0;
                anyd_found_r <= 1'b0;
                state_r <= B_SCAN;
              end
              KIND_NEW: begin
                if (q_item.flow_end && flows_r != CNT_MAX) flows_r <= flows_r + 24'd1;
                state_r <= B_DIV_LEN;
              end
              default: state_r <= B_IDLE;
            endcase
          end
        end
        B_DIV_LEN: begin
          if (div_done) begin
            mlen_r <= (div_quo > DIV_NW'(MLEN_MAX)) ? MLEN_MAX : div_quo[25:0];
            if (div_gap_ok) begin
              state_r <= B_DIV_GAP;
            end else begin
              gap_r <= '0;
              state_r <= B_EMIT;
            end
          end
        end
        B_DIV_GAP: begin
          if (div_done) begin
            gap_r <= (div_quo > DIV_NW'(GAP_MAX)) ? GAP_MAX : div_quo[19:0];
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            o_bucket_r <= cur_bucket_r;
            o_flows_r <= flows_r;
            o_packets_r <= packets_r;
            o_bytes_r <= bytes_r;
            o_mlen_r <= mlen_r;
            o_gap_r <= gap_r;
            o_src_r <= 7'(src_fill_r);
            o_dst_r <= 7'(dst_fill_r);
            o_any_r <= 8'(any_fill_r);
            o_ovf_r <= ovf_r;
            state_r <= B_OPEN;
          end
        end
        B_OPEN: begin
          cur_bucket_r <= it_r.bucket;
          packets_r <= 24'd1;
          bytes_r <= {16'd0, it_r.len};
          first_r <= it_r.t;
          last_r <= it_r.t;
          flows_r <= '0;
          src_fill_r <= '0;
          dst_fill_r <= '0;
          any_fill_r <= '0;
          ovf_r <= 1'b0;
          scan_k_r <= '0;
          kv_r <= 1'b0;
          src_found_r <= 1'b0;
          dst_found_r <= 1'b0;
          anys_found_r <= 1'b0;
          anyd_found_r <= 1'b0;
          state_r <= B_SCAN;
        end
        B_SCAN: begin
          if (hit_src) src_found_r <= 1'b1;
          if (hit_dst) dst_found_r <= 1'b1;
          if (hit_anys) anys_found_r <= 1'b1;
          if (hit_anyd) anyd_found_r <= 1'b1;
          kd_r <= scan_k_r;
          kv_r <= (scan_k_r < lim);
          if (scan_k_r == lim) begin
            state_r <= B_INS_A;
          end else begin
            scan_k_r <= scan_k_r + 1'b1;
          end
        end
        B_INS_A: begin
          if (src_we) src_fill_r <= src_fill_r + 1'b1;
          if (dst_we) dst_fill_r <= dst_fill_r + 1'b1;
          if (any_we) any_fill_r <= any_fill_r + 1'b1;
          if ((src_new && !src_we) || (dst_new && !dst_we) || (anys_new && !any_we)) begin
            ovf_r <= 1'b1;
          end
          state_r <= B_INS_B;
        end
        B_INS_B: begin
          if (any_we) any_fill_r <= any_fill_r + 1'b1;
          if (anyd_new && !any_we) ovf_r <= 1'b1;
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_empty = !out_valid_r;
  assign out_bucket_number = o_bucket_r;
  assign out_flow_count = o_flows_r;
  assign out_packet_count = o_packets_r;
  assign out_byte_total = o_bytes_r;
  assign out_mean_length_milli = o_mlen_r;
  assign out_mean_gap_micros = o_gap_r;
  assign out_distinct_sources = o_src_r;
  assign out_distinct_destinations = o_dst_r;
  assign out_distinct_any = o_any_r;
  assign out_table_overflow = o_ovf_r;

endmodule
`default_nettype wire

### sv/per_second_traffic_stats.sv
// Per-second traffic statistics: packet records go in through a push/full
// port and one report per closed one-second bucket comes out through an
// empty/pop port. The front end holds in_full high while it works on a
// record, so it takes a new one only once the last is queued or dropped;
// a four-entry queue decouples it from the back end. In the back end a
// record that stays in the open bucket is checked by a one-entry-per-cycle
// scan of the address set memories; a record that closes a bucket first
// runs a 52-step division for the mean length and, with two or more packets,
// a second for the mean gap, before the report is posted and the new bucket
// is opened. The last open bucket is never reported; late records are dropped.
`timescale 1ns / 1ps
`default_nettype none
module per_second_traffic_stats import ptss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [31:0] in_ts_seconds,
  input  wire logic [19:0] in_ts_micros,
  input  wire logic [15:0] in_packet_length,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_bucket_number,
  output logic [23:0]      out_flow_count,
  output logic [23:0]      out_packet_count,
  output logic [31:0]      out_byte_total,
  output logic [25:0]      out_mean_length_milli,
  output logic [19:0]      out_mean_gap_micros,
  output logic [6:0]       out_distinct_sources,
  output logic [6:0]       out_distinct_destinations,
  output logic [7:0]       out_distinct_any,
  output logic             out_table_overflow
);

  logic  f_push;
  item_t f_item;
  logic  q_full;
  logic  q_pop;
  item_t q_item;
  logic  q_empty;

  // Front end: bucket placement and flow tracking.
  ptss_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_ts_seconds    (in_ts_seconds),
    .in_ts_micros     (in_ts_micros),
    .in_packet_length (in_packet_length),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .q_push           (f_push),
    .q_item           (f_item),
    .q_full           (q_full)
  );

  // Item queue.
  ptss_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  // Back end: totals, address sets and reports.
  ptss_back u_back (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .q_empty                   (q_empty),
    .q_pop                     (q_pop),
    .q_item                    (q_item),
    .out_empty                 (out_empty),
    .out_pop                   (out_pop),
    .out_bucket_number         (out_bucket_number),
    .out_flow_count            (out_flow_count),
    .out_packet_count          (out_packet_count),
    .out_byte_total            (out_byte_total),
    .out_mean_length_milli     (out_mean_length_milli),
    .out_mean_gap_micros       (out_mean_gap_micros),
    .out_distinct_sources      (out_distinct_sources),
    .out_distinct_destinations (out_distinct_destinations),
    .out_distinct_any          (out_distinct_any),
    .out_table_overflow        (out_table_overflow)
  );

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the per-second traffic statistics block.
// Holds a bucket predictor inside a small scoreboard class, the drivers and
// the output checker. Depends on ptss_pkg and per_second_traffic_stats.
`timescale 1ns / 1ps
`default_nettype none
module tb_top import ptss_pkg::*;;

  localparam longint unsigned USEC = 1000000;
  localparam longint unsigned ORIGIN_US = 500000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 500;

  // One bucket report as the block presents it.
  typedef struct packed {
    logic [31:0] bucket_number;
    logic [23:0] flow_count;
    logic [23:0] packet_count;
    logic [31:0] byte_total;
    logic [25:0] mean_length_milli;
    logic [19:0] mean_gap_micros;
    logic [6:0]  distinct_sources;
    logic [6:0]  distinct_destinations;
    logic [7:0]  distinct_any;
    logic        table_overflow;
  } report_t;

  // Predicts bucket reports from accepted packets and checks the block's.
  class traffic_scoreboard;
    report_t     report_q[$];
    int unsigned mismatches = 0;
    bit          started = 0;
    logic [63:0] origin = 0;
    logic [31:0] open_bucket_no = 1;
    logic [23:0] pkts = 0;
    logic [31:0] bytes = 0;
    logic [63:0] t_first = 0, t_last = 0;
    logic [31:0] last_sa = 0, last_da = 0;
    logic [15:0] last_sp = 0, last_dp = 0;
    bit          run_open = 0;
    logic [23:0] flows = 0;
    logic [31:0] src_seen[$], dst_seen[$], any_seen[$];
    bit          overflowed = 0;

    function void remember(ref logic [31:0] seen[$], input logic [31:0] a, input int cap);
      foreach (seen[k]) if (seen[k] == a) return;
      if (seen.size() < cap) seen.insert(seen.size(), a);
      else overflowed = 1;
    endfunction

    function void add_addrs(logic [31:0] sa, logic [31:0] da);
      remember(src_seen, sa, MAX_ADDRS);
      remember(dst_seen, da, MAX_ADDRS);
      remember(any_seen, sa, ANY_ADDRS);
      remember(any_seen, da, ANY_ADDRS);
    endfunction

    function void start_bucket(logic [63:0] t, logic [15:0] len, logic [31:0] sa,
                               logic [31:0] da);
      pkts = 1;
      bytes = {16'b0, len};
      t_first = t;
      t_last = t;
      flows = 0;
      src_seen.delete();
      dst_seen.delete();
      any_seen.delete();
      overflowed = 0;
      run_open = 0;
      add_addrs(sa, da);
    endfunction

    // Called for every packet the block accepts.
    function void note_packet(logic [31:0] sec, logic [19:0] us, logic [15:0] len,
                              logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                              logic [15:0] dp);
      logic [63:0] t, q, span, v;
      logic [31:0] bkt;
      bit same;
      report_t r;
      t = {32'b0, sec} * USEC + {44'b0, us};
      if (!started) begin
        started = 1;
        origin = t;
        open_bucket_no = 1;
        start_bucket(t, len, sa, da);
        {last_sa, last_da, last_sp, last_dp} = {sa, da, sp, dp};
        return;
      end
      // Late packets leave no trace.
      if (t < origin) return;
      q = (t - origin) / USEC;
      bkt = (q >= 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0] + 32'd1;
      if (bkt < open_bucket_no) return;
      // Flow tracking: a run of matching neighbors ends at a mismatch.
      same = ((last_sa == sa && last_da == da) || (last_sa == da && last_da == sa)) &&
             ((last_sp == sp && last_dp == dp) || (last_sp == dp && last_dp == sp));
      if (same) run_open = 1;
      else if (run_open) begin
        if (flows != 24'hFFFFFF) flows++;
        run_open = 0;
      end
      {last_sa, last_da, last_sp, last_dp} = {sa, da, sp, dp};
      if (bkt == open_bucket_no) begin
        if (pkts != 24'hFFFFFF) pkts++;
        v = {32'b0, bytes} + {48'b0, len};
        bytes = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        t_last = t;
        add_addrs(sa, da);
        return;
      end
      // The packet opens a later bucket: close the current one.
      r.bucket_number = open_bucket_no;
      r.flow_count = flows;
      r.packet_count = pkts;
      r.byte_total = bytes;
      v = (pkts != 0) ? ({32'b0, bytes} * 64'd1000) / {40'b0, pkts} : 64'd0;
      r.mean_length_milli = (v > 64'd65535000) ? 26'd65535000 : v[25:0];
      span = (t_last >= t_first) ? t_last - t_first : 64'd0;
      v = (pkts >= 2) ? span / ({40'b0, pkts} - 64'd1) : 64'd0;
      r.mean_gap_micros = (v > 64'd999999) ? 20'd999999 : v[19:0];
      r.distinct_sources = (src_seen.size() > 127) ? 7'd127 : 7'(src_seen.size());
      r.distinct_destinations = (dst_seen.size() > 127) ? 7'd127 : 7'(dst_seen.size());
      r.distinct_any = (any_seen.size() > 255) ? 8'd255 : 8'(any_seen.size());
      r.table_overflow = overflowed;
      report_q.insert(report_q.size(), r);
      open_bucket_no = bkt;
      start_bucket(t, len, sa, da);
    endfunction

    // Called for every report the block hands out.
    function void check_report(report_t got);
      report_t want;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %p", got);
        return;
      end
      want = report_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("report mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_full;
  logic [31:0] in_ts_seconds = 0;
  logic [19:0] in_ts_micros = 0;
  logic [15:0] in_packet_length = 0;
  logic [31:0] in_src_addr = 0;
  logic [31:0] in_dst_addr = 0;
  logic [15:0] in_src_port = 0;
  logic [15:0] in_dst_port = 0;
  logic        out_empty;
  logic        out_pop = 0;
  report_t     out_report;

  traffic_scoreboard sb = new();
  int tx_idle_pct = 31;
  int rx_idle_pct = 61;
  int cycles = 0;
  int sent = 0;

  per_second_traffic_stats dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_ts_seconds(in_ts_seconds), .in_ts_micros(in_ts_micros),
    .in_packet_length(in_packet_length), .in_src_addr(in_src_addr),
    .in_dst_addr(in_dst_addr), .in_src_port(in_src_port), .in_dst_port(in_dst_port),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_bucket_number(out_report.bucket_number),
    .out_flow_count(out_report.flow_count),
    .out_packet_count(out_report.packet_count),
    .out_byte_total(out_report.byte_total),
    .out_mean_length_milli(out_report.mean_length_milli),
    .out_mean_gap_micros(out_report.mean_gap_micros),
    .out_distinct_sources(out_report.distinct_sources),
    .out_distinct_destinations(out_report.distinct_destinations),
    .out_distinct_any(out_report.distinct_any),
    .out_table_overflow(out_report.table_overflow)
  );

  always #4 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Predict on every accepted item and check every accepted report.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full)
      sb.note_packet(in_ts_seconds, in_ts_micros, in_packet_length, in_src_addr,
                     in_dst_addr, in_src_port, in_dst_port);
    if (rst_n && out_pop && !out_empty) sb.check_report(out_report);
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst_n) out_pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Offers one packet and returns once it is accepted; push stays high.
  task automatic send_packet(logic [31:0] sec, logic [19:0] us, logic [15:0] len,
                             logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                             logic [15:0] dp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_ts_seconds <= sec;
    in_ts_micros <= us;
    in_packet_length <= len;
    in_src_addr <= sa;
    in_dst_addr <= da;
    in_src_port <= sp;
    in_dst_port <= dp;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  // Sends a packet at an absolute time, sometimes with the micros part over range.
  task automatic send_at(longint unsigned t, logic [15:0] len, logic [31:0] sa,
                         logic [31:0] da, logic [15:0] sp, logic [15:0] dp);
    longint unsigned sec, us;
    sec = t / USEC;
    us = t % USEC;
    if (us <= 48575 && sec > 0 && $urandom_range(3) == 0) begin
      sec--;
      us += USEC;
    end
    send_packet(sec[31:0], us[19:0], len, sa, da, sp, dp);
  endtask

  // Holds off the sender until every predicted report has come out.
  task automatic drain_reports();
    in_push <= 0;
    @(posedge clk);
    while (sb.report_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] pool_sa[6], pool_da[6];
    logic [15:0] pool_sp[6], pool_dp[6];
    logic [31:0] sa, da;
    logic [15:0] sp, dp;
    longint unsigned now, start, step, t;
    int n, k;

    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: origin at 0.5 s.
    send_packet(0, 500000, 0, 32'h0A000001, 32'hFFFFFFFF, 16'hFFFF, 16'd80);
    send_packet(0, 100, 5, 32'h1, 32'h2, 1, 2);                         // before origin
    send_packet(0, 700000, 16'hFFFF, 32'h0A000001, 32'hFFFFFFFF, 16'hFFFF, 16'd80);
    send_packet(0, 900000, 100, 32'hFFFFFFFF, 32'h0A000001, 16'd80, 16'hFFFF);
    send_packet(0, 600000, 60, 32'h0, 32'hC0A80001, 0, 0);              // out of order
    send_packet(1, 100000, 1500, 32'h0, 32'hC0A80001, 0, 0);
    send_packet(1, 20'hFFFFF, 40, 32'h0, 32'hC0A80001, 0, 0);           // micros over range
    send_packet(3, 0, 64, 32'hC0A80001, 32'h0, 16'd1234, 16'd443);
    send_packet(3, 200000, 64, 32'hC0A80001, 32'h0, 16'd443, 16'd1234); // ports swapped
    send_packet(10, 0, 9000, 32'h12345678, 32'h87654321, 16'h8000, 16'h7FFF);
    send_packet(10, 1, 9000, 32'h12345678, 32'h87654321, 16'h8000, 16'h7FFF);
    send_packet(2, 0, 1, 32'h1, 32'h1, 1, 1);                           // earlier bucket
    send_packet(11, 0, 2, 32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555);

    foreach (pool_sa[i]) begin
      pool_sa[i] = $urandom;
      pool_da[i] = $urandom;
      pool_sp[i] = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
      pool_dp[i] = 16'($urandom);
    end
    {sa, da, sp, dp} = {pool_sa[0], pool_da[0], pool_sp[0], pool_dp[0]};
    now = 11 * USEC + 2;
    k = 0;

    // Random part: whole buckets of packets with traffic from a small pool.
    while (k < RANDOM_ITEMS) begin
      if (k >= RANDOM_ITEMS / 3 && tx_idle_pct == 31) begin
        drain_reports();
        tx_idle_pct = 61;
        rx_idle_pct = 31;
      end else if (k >= 2 * RANDOM_ITEMS / 3 && tx_idle_pct == 61) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      n = ($urandom_range(14) == 0) ? 70 : $urandom_range(1, 10);
      start = ORIGIN_US + ((now - ORIGIN_US) / USEC + 1 + $urandom_range(2)) * USEC;
      step = USEC / (n + 1);
      for (int i = 0; i < n; i++) begin
        if (n == 70 || $urandom_range(7) == 0)
          {sa, da, sp, dp} = {$urandom, $urandom, 16'($urandom), 16'($urandom)};
        else if ($urandom_range(1) == 0) begin
          if ($urandom_range(2) == 0) {sa, da} = {da, sa};
          if ($urandom_range(2) == 0) {sp, dp} = {dp, sp};
        end else begin
          int j = $urandom_range(5);
          {sa, da, sp, dp} = {pool_sa[j], pool_da[j], pool_sp[j], pool_dp[j]};
        end
        t = start + i * step + $urandom_range(step - 1);
        // Occasional noise: a late packet or one out of order in the bucket.
        if ($urandom_range(19) == 0) begin
          send_at(start - 1 - $urandom_range(2 * USEC), 16'($urandom), sa, da, sp, dp);
          k++;
        end else if ($urandom_range(19) == 0 && t > start) begin
          t = start + $urandom_range(t - start);
        end
        send_at(t, 16'($urandom), sa, da, sp, dp);
        now = (t > now) ? t : now;
        k++;
      end
    end

    // Far future: the bucket index saturates, closing the last normal bucket.
    send_packet(32'hFFFFFFFF, 20'd999999, 16'd7, sa, da, sp, dp);
    send_packet(32'hFFFFFFFF, 20'd999999, 16'd9, da, sa, dp, sp);
    in_push <= 0;

    while (sb.report_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.mismatches == 0 && sb.report_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
sv/ptss_pkg.sv
sv/ptss_div.sv
sv/ptss_fifo.sv
sv/ptss_front.sv
sv/ptss_back.sv
sv/per_second_traffic_stats.sv
bench/tb_top.sv
